// ===== hdl/bmpq_pkg.sv =====
// Package for the bounded minimum priority queue.
// Holds field widths, operation and status codes and reset constants; no dependencies.
`default_nettype none

package bmpq_pkg;

   localparam int DEPTH_DEFAULT = 8;
   localparam int FUNC_W        = 2;
   localparam int TAG_W         = 16;
   localparam int PRIO_W        = 32;
   localparam int STATUS_W      = 3;
   localparam int LIMIT_W       = 4;
   localparam int REQ_DATA_W    = 56;
   localparam int RSP_DATA_W    = 56;
   localparam int CSR_ADDR_W    = 1;
   localparam int CSR_DATA_W    = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd5;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_POP    = 2'd1,
      FUNC_PEEK   = 2'd2,
      FUNC_UNUSED = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 3'd0,
      ST_FULL     = 3'd1,
      ST_POPPED   = 3'd2,
      ST_PEEKED   = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   localparam logic [CSR_ADDR_W-1:0] REG_CAPACITY_LIMIT = 1'd0;

endpackage

`default_nettype wire

// ===== hdl/bounded_min_priority_queue.sv =====
// A request transfer gives its response in the next cycle, from the response register.
// Throughput: one request per cycle while responses are taken; a request is taken whenever
// the response register is empty or leaving, set by the single response register.
// Reset: synchronous, clears the entry count and the response valid, limit returns to 5.
// Top level of the bounded minimum priority queue: sorted register store, parallel compares.
// Depends on bmpq_pkg.
`default_nettype none

module bounded_min_priority_queue
   import bmpq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire                     clock,
   input  wire                     reset,
   // req_tdata: func[1:0], tag_in[17:2], prio_in[49:18], zero fill
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  wire  [REQ_DATA_W-1:0]   req_tdata,
   // rsp_tdata: status[2:0], tag_out[18:3], prio_out[50:19], zero fill
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   input  wire                     csr_psel,
   input  wire                     csr_penable,
   input  wire                     csr_pwrite,
   input  wire  [CSR_ADDR_W-1:0]   csr_paddr,
   input  wire  [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   logic [LIMIT_W-1:0]       limit_ff, limit_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [TAG_W-1:0]         tag_ff  [DEPTH];
   logic [TAG_W-1:0]         tag_in  [DEPTH];
   logic signed [PRIO_W-1:0] prio_ff [DEPTH];
   logic signed [PRIO_W-1:0] prio_in [DEPTH];
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   func_type                 req_func;
   logic [TAG_W-1:0]         req_tag;
   logic signed [PRIO_W-1:0] req_prio;
   logic                     req_fire;
   logic                     csr_write;
   logic                     is_full;
   logic                     is_empty;
   logic [DEPTH-1:0]         shift_up;
   status_type               status;
   logic [TAG_W-1:0]         tag_out;
   logic [PRIO_W-1:0]        prio_out;

   assign req_func = func_type'(req_tdata[FUNC_W-1:0]);
   assign req_tag  = req_tdata[FUNC_W +: TAG_W];
   assign req_prio = req_tdata[FUNC_W+TAG_W +: PRIO_W];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == REG_CAPACITY_LIMIT) ?
                       CSR_DATA_W'(limit_ff) : '0;

   assign is_full  = (CMP_W'(count_ff) >= CMP_W'(limit_ff)) ||
                     (CMP_W'(count_ff) >= CMP_W'(DEPTH));
   assign is_empty = (count_ff == '0);

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         shift_up[i] = (CNT_W'(i) < count_ff) && (req_prio < prio_ff[i]);
      end
   end

   always_comb begin
      limit_in = limit_ff;
      if (csr_write && csr_paddr == REG_CAPACITY_LIMIT) begin
         limit_in = csr_pwdata[LIMIT_W-1:0];
      end
   end

   always_comb begin
      count_in = count_ff;
      status   = ST_EMPTY;
      tag_out  = '0;
      prio_out = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tag_in[i]  = tag_ff[i];
         prio_in[i] = prio_ff[i];
      end
      priority if (req_func == FUNC_INSERT) begin
         if (is_full) begin
            status = ST_FULL;
         end else begin
            status = ST_INSERTED;
            if (req_fire) begin
               count_in = count_ff + CNT_W'(1);
               for (int i = 0; i < DEPTH; i++) begin
                  if (i > 0 && shift_up[(i > 0) ? i - 1 : 0]) begin
                     tag_in[i]  = tag_ff[(i > 0) ? i - 1 : 0];
                     prio_in[i] = prio_ff[(i > 0) ? i - 1 : 0];
                  end else if (shift_up[i] || CNT_W'(i) == count_ff) begin
                     tag_in[i]  = req_tag;
                     prio_in[i] = req_prio;
                  end
               end
            end
         end
      end else if (is_empty) begin
         status = ST_EMPTY;
      end else begin
         tag_out  = tag_ff[0];
         prio_out = prio_ff[0];
         if (req_func == FUNC_POP) begin
            status = ST_POPPED;
            if (req_fire) begin
               count_in = count_ff - CNT_W'(1);
               for (int i = 0; i < DEPTH - 1; i++) begin
                  tag_in[i]  = tag_ff[i+1];
                  prio_in[i] = prio_ff[i+1];
               end
            end
         end else begin
            status = ST_PEEKED;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'({prio_out, tag_out, status});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      for (int i = 0; i < DEPTH; i++) begin
         tag_ff[i]  <= tag_in[i];
         prio_ff[i] <= prio_in[i];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/bmpq_checker.sv =====
// Port-level checker for the bounded minimum priority queue, bound to the top level.
// Depends on bmpq_pkg and bounded_min_priority_queue.
`default_nettype none

module bmpq_checker
   import bmpq_pkg::*;
(
   input wire                   clock,
   input wire                   reset,
   input wire                   req_tvalid,
   input wire                   req_tready,
   input wire                   rsp_tvalid,
   input wire                   rsp_tready,
   input wire [RSP_DATA_W-1:0]  rsp_tdata
);

   logic [STATUS_W-1:0] st;
   logic                no_payload;

   assign st = rsp_tdata[STATUS_W-1:0];
   assign no_payload = (st == ST_INSERTED) || (st == ST_FULL) || (st == ST_EMPTY);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("request transfer without response next cycle");

   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && no_payload |-> rsp_tdata[RSP_DATA_W-1:STATUS_W] == '0)
      else $error("nonzero tag or priority without an entry");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind bounded_min_priority_queue bmpq_checker u_bmpq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
